### sv/lgms_pkg.sv
// Package for the largest-gap midpoint seat allocator.
// Holds field widths, status, mode and register codes and parameter defaults.
// No dependencies; every file but lgms_ram and lgms_gap_unit imports it.
package lgms_pkg;

  // Field widths of the streaming and configuration ports.
  localparam int STUDENT_W    = 10;
  localparam int SEAT_W       = 11;
  localparam int MIN_DIST_W   = 11;
  localparam int STATUS_W     = 2;
  localparam int CFG_W        = 11;
  localparam int CFG_INDEX_W  = 1;
  localparam int IN_DATA_W    = 16;
  localparam int OUT_DATA_W   = 24;

  // Largest seat count the seat_count register can express.
  localparam int SEAT_FIELD_MAX = 2047;
  // Number of student ids the student field can express.
  localparam int STUDENT_IDS    = 1024;

  // Parameter defaults and register reset values.
  localparam int DEF_MAX_SEATS     = 1024;
  localparam int DEF_MAX_STUDENTS  = 1024;
  localparam int SEAT_COUNT_RESET  = 1024;
  localparam int REQ_DIST_RESET    = 1;

  // Request modes.
  localparam logic MODE_ENTER = 1'b0;
  localparam logic MODE_LEAVE = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_SEATED = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_SEAT_COUNT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REQ_DIST   = 1'd1;

endpackage

### sv/lgms_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Standalone; used for the occupancy map and the student seat table.
module lgms_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### sv/lgms_gap_unit.sv
// Shared subtract and compare unit of the seat allocator.
// Used for the gap search during the scan and for the neighbour distances
// when a seat is taken. No package dependencies.
module lgms_gap_unit #(
  parameter int W = 11
) (
  input  logic [W-1:0] lo,
  input  logic [W-1:0] hi,
  input  logic [W-1:0] thresh,
  output logic [W-1:0] diff,
  output logic [W-1:0] half,
  output logic         half_gt,
  output logic         diff_lt
);

  // Distance between the two positions and its half-length.
  assign diff    = hi - lo;
  assign half    = diff >> 1;

  // Comparisons against the threshold.
  assign half_gt = (half > thresh);
  assign diff_lt = (diff < thresh);

endmodule

### sv/largest_gap_midpoint_seat_allocator.sv
// An enter request scans the row one position per cycle through the occupancy
// RAM and the shared gap unit; a leave request looks up the student seat table.
// One request is in work at a time, and s_axis_tready stays low until it has
// reached the output register. After reset and after every write of seat_count
// the block sweeps both tables, one entry per cycle, over the depth of the
// deeper table, with s_axis_tready low.
// Depends on lgms_pkg, lgms_ram and lgms_gap_unit.
module largest_gap_midpoint_seat_allocator
  import lgms_pkg::*;
#(
  parameter int MAX_SEATS    = DEF_MAX_SEATS,
  parameter int MAX_STUDENTS = DEF_MAX_STUDENTS
) (
  input  logic                   clk,
  input  logic                   rst,
  // Input stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,   // [9:0] student, [15:10] zero
  input  logic [0:0]             s_axis_tuser,   // [0] mode
  // Result stream.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,   // [10:0] seat, [21:11] min_distance,
                                                 // [22] distance_ok, [23] zero
  output logic [STATUS_W-1:0]    m_axis_tuser,   // [1:0] status
  // Configuration writes.
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata
);

  // Sizes that follow from the parameters and the field widths.
  localparam int EFF_SEATS  = (MAX_SEATS < SEAT_FIELD_MAX) ? MAX_SEATS : SEAT_FIELD_MAX;
  localparam int EFF_ST     = (MAX_STUDENTS < STUDENT_IDS) ? MAX_STUDENTS : STUDENT_IDS;
  localparam int POS_W      = $clog2(EFF_SEATS + 2);
  localparam int SEAT_AW    = (EFF_SEATS > 1) ? $clog2(EFF_SEATS) : 1;
  localparam int ST_AW      = (EFF_ST > 1) ? $clog2(EFF_ST) : 1;
  localparam int CLR_DEPTH  = (EFF_SEATS > EFF_ST) ? EFF_SEATS : EFF_ST;
  localparam int CLR_W      = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;
  localparam int SC_RESET   = (EFF_SEATS < SEAT_COUNT_RESET) ? EFF_SEATS : SEAT_COUNT_RESET;
  localparam logic [CFG_W-1:0] EFF_SEATS_V = CFG_W'(EFF_SEATS);

  // Sequencer states.
  localparam logic [3:0] ST_CLEAR   = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_SCAN    = 4'd2;
  localparam logic [3:0] ST_MID     = 4'd3;
  localparam logic [3:0] ST_PLACE_L = 4'd4;
  localparam logic [3:0] ST_PLACE_R = 4'd5;
  localparam logic [3:0] ST_LV_ADDR = 4'd6;
  localparam logic [3:0] ST_LV_CHK  = 4'd7;
  localparam logic [3:0] ST_RESULT  = 4'd8;

  logic [3:0]           state;
  logic [CLR_W-1:0]     clr_cnt;
  logic [POS_W-1:0]     seat_count;
  logic [CFG_W-1:0]     required_distance;
  logic [POS_W-1:0]     running_min;

  // Request in work.
  logic [STUDENT_W-1:0] stu_r;
  logic                 stu_in_range;

  // Scan state.
  logic [POS_W-1:0]     scan_p;
  logic [POS_W-1:0]     chk_p;
  logic                 chk_v;
  logic [POS_W-1:0]     prev;
  logic [POS_W-1:0]     best_half;
  logic [POS_W-1:0]     best_l;
  logic [POS_W-1:0]     best_r;
  logic [POS_W-1:0]     mid;
  logic [POS_W-1:0]     wall;
  logic                 chk_occ;

  // Result being formed and the output register.
  logic [POS_W-1:0]     seat_r;
  logic [STATUS_W-1:0]  status_r;
  logic [SEAT_W-1:0]    out_seat;
  logic [MIN_DIST_W-1:0] out_min;
  logic                 out_ok;
  logic [STATUS_W-1:0]  out_status;
  logic                 out_valid;
  logic                 seat_cfg_wr;
  logic                 load_out;

  // Memory ports.
  logic                 occ_we;
  logic [SEAT_AW-1:0]   occ_waddr;
  logic                 occ_wdata;
  logic [SEAT_AW-1:0]   occ_raddr;
  logic                 occ_rdata;
  logic                 st_we;
  logic [ST_AW-1:0]     st_waddr;
  logic [POS_W-1:0]     st_wdata;
  logic [POS_W-1:0]     st_rdata;
  logic [POS_W-1:0]     leave_seat;
  logic                 leave_ok;

  // Shared unit ports.
  logic [POS_W-1:0]     gu_lo;
  logic [POS_W-1:0]     gu_hi;
  logic [POS_W-1:0]     gu_thresh;
  logic [POS_W-1:0]     gu_diff;
  logic [POS_W-1:0]     gu_half;
  logic                 gu_half_gt;
  logic                 gu_diff_lt;

  logic [POS_W-1:0]     cfg_seats;

  assign wall         = seat_count + POS_W'(1);
  assign stu_in_range = ({1'b0, stu_r} < (STUDENT_W + 1)'(EFF_ST));
  assign chk_occ      = (chk_p == wall) || occ_rdata;
  assign leave_seat   = stu_in_range ? st_rdata : '0;
  assign leave_ok     = (leave_seat != '0) && (leave_seat <= seat_count);

  // A seat_count write restarts the block; the output register loads in the result state.
  assign seat_cfg_wr  = cfg_we && (cfg_index == CFG_SEAT_COUNT);
  assign load_out     = (state == ST_RESULT) && (!out_valid || m_axis_tready) && !seat_cfg_wr;

  // A seat_count write is held to the range 1 .. min(MAX_SEATS, 2047).
  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_seats = POS_W'(1);
    end else if (cfg_wdata > EFF_SEATS_V) begin
      cfg_seats = POS_W'(EFF_SEATS);
    end else begin
      cfg_seats = POS_W'(cfg_wdata);
    end
  end

  // Occupancy map of seats 1 .. seat_count; the walls are not stored.
  lgms_ram #(
    .WIDTH (1),
    .DEPTH (EFF_SEATS),
    .AW    (SEAT_AW)
  ) u_occ_ram (
    .clk   (clk),
    .we    (occ_we),
    .waddr (occ_waddr),
    .wdata (occ_wdata),
    .raddr (occ_raddr),
    .rdata (occ_rdata)
  );

  // Seat held by each student, zero when not seated.
  lgms_ram #(
    .WIDTH (POS_W),
    .DEPTH (EFF_ST),
    .AW    (ST_AW)
  ) u_st_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (ST_AW'(stu_r)),
    .rdata (st_rdata)
  );

  // Shared subtract and compare unit.
  lgms_gap_unit #(
    .W (POS_W)
  ) u_gap_unit (
    .lo      (gu_lo),
    .hi      (gu_hi),
    .thresh  (gu_thresh),
    .diff    (gu_diff),
    .half    (gu_half),
    .half_gt (gu_half_gt),
    .diff_lt (gu_diff_lt)
  );

  // Operand selection for the shared unit.
  always_comb begin
    gu_lo     = prev;
    gu_hi     = chk_p;
    gu_thresh = best_half;
    if (state == ST_PLACE_L) begin
      gu_lo     = best_l;
      gu_hi     = mid;
      gu_thresh = running_min;
    end else if (state == ST_PLACE_R) begin
      gu_lo     = mid;
      gu_hi     = best_r;
      gu_thresh = running_min;
    end
  end

  // Scan read address: seat p lives at entry p-1.
  assign occ_raddr = SEAT_AW'(scan_p - POS_W'(1));

  // Memory writes: clearing sweep, seat taken, seat freed.
  always_comb begin
    occ_we    = 1'b0;
    occ_waddr = SEAT_AW'(clr_cnt);
    occ_wdata = 1'b0;
    st_we     = 1'b0;
    st_waddr  = ST_AW'(clr_cnt);
    st_wdata  = '0;
    if (state == ST_CLEAR) begin
      occ_we = ({1'b0, clr_cnt} < (CLR_W + 1)'(EFF_SEATS));
      st_we  = ({1'b0, clr_cnt} < (CLR_W + 1)'(EFF_ST));
    end else if (state == ST_PLACE_R) begin
      occ_we    = 1'b1;
      occ_waddr = SEAT_AW'(mid - POS_W'(1));
      occ_wdata = 1'b1;
      st_we     = stu_in_range;
      st_waddr  = ST_AW'(stu_r);
      st_wdata  = mid;
    end else if ((state == ST_LV_CHK) && leave_ok) begin
      occ_we    = 1'b1;
      occ_waddr = SEAT_AW'(leave_seat - POS_W'(1));
      occ_wdata = 1'b0;
      st_we     = 1'b1;
      st_waddr  = ST_AW'(stu_r);
      st_wdata  = '0;
    end
  end

  assign s_axis_tready = (state == ST_IDLE);

  // Sequencer, configuration registers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_CLEAR;
      clr_cnt           <= '0;
      seat_count        <= POS_W'(SC_RESET);
      running_min       <= POS_W'(SC_RESET + 1);
      required_distance <= CFG_W'(REQ_DIST_RESET);
      out_valid         <= 1'b0;
      chk_v             <= 1'b0;
    end else begin
      // A new seat count empties the row and restarts the clearing sweep.
      if (seat_cfg_wr) begin
        seat_count  <= cfg_seats;
        running_min <= cfg_seats + POS_W'(1);
        clr_cnt     <= '0;
        state       <= ST_CLEAR;
      end else begin
        unique case (state)
          ST_CLEAR: begin
            clr_cnt <= clr_cnt + CLR_W'(1);
            if (clr_cnt == CLR_W'(CLR_DEPTH - 1)) begin
              state <= ST_IDLE;
            end
          end
          ST_IDLE: begin
            if (s_axis_tvalid) begin
              stu_r     <= s_axis_tdata[STUDENT_W-1:0];
              scan_p    <= POS_W'(1);
              chk_v     <= 1'b0;
              prev      <= '0;
              best_half <= '0;
              best_l    <= '0;
              best_r    <= '0;
              state     <= (s_axis_tuser[0] == MODE_LEAVE) ? ST_LV_ADDR : ST_SCAN;
            end
          end
          ST_SCAN: begin
            // Issue the next position; stop advancing at the right wall.
            chk_p <= scan_p;
            if (scan_p != wall) begin
              scan_p <= scan_p + POS_W'(1);
            end
            // Judge the position read in the previous cycle.
            if (chk_v && chk_occ) begin
              if (gu_half_gt) begin
                best_half <= gu_half;
                best_l    <= prev;
                best_r    <= chk_p;
              end
              prev <= chk_p;
            end
            // The scan ends once the right wall has been judged.
            if (chk_v && chk_occ && (chk_p == wall)) begin
              chk_v <= 1'b0;
              state <= ST_MID;
            end else begin
              chk_v <= 1'b1;
            end
          end
          ST_MID: begin
            if (best_half == '0) begin
              seat_r   <= '0;
              status_r <= STATUS_FULL;
              state    <= ST_RESULT;
            end else begin
              mid   <= POS_W'(({1'b0, best_l} + {1'b0, best_r}) >> 1);
              state <= ST_PLACE_L;
            end
          end
          ST_PLACE_L: begin
            if ((best_l != '0) && gu_diff_lt) begin
              running_min <= gu_diff;
            end
            state <= ST_PLACE_R;
          end
          ST_PLACE_R: begin
            if ((best_r != wall) && gu_diff_lt) begin
              running_min <= gu_diff;
            end
            seat_r   <= mid;
            status_r <= STATUS_OK;
            state    <= ST_RESULT;
          end
          ST_LV_ADDR: begin
            state <= ST_LV_CHK;
          end
          ST_LV_CHK: begin
            seat_r   <= leave_ok ? leave_seat : '0;
            status_r <= leave_ok ? STATUS_OK : STATUS_NOT_SEATED;
            state    <= ST_RESULT;
          end
          ST_RESULT: begin
            if (load_out) begin
              out_seat   <= SEAT_W'(seat_r);
              out_min    <= MIN_DIST_W'(running_min);
              out_ok     <= ((POS_W + CFG_W)'(running_min) >=
                             (POS_W + CFG_W)'(required_distance));
              out_status <= status_r;
              state      <= ST_IDLE;
            end
          end
          default: begin
            state <= ST_IDLE;
          end
        endcase
      end

      // Required distance write.
      if (cfg_we && (cfg_index == CFG_REQ_DIST)) begin
        required_distance <= cfg_wdata;
      end

      // The output register fills from the result state and empties on a transfer.
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result stream outputs.
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_ok, out_min, out_seat};
  assign m_axis_tuser  = out_status;

endmodule

### sv/lgms_checker.sv
// Port-level checker for the largest-gap midpoint seat allocator.
// Depends on lgms_pkg; bound to the top level at the end of this file.
module lgms_checker
  import lgms_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [STATUS_W-1:0]   m_axis_tuser
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

  // Only one request is in work: the input closes after a transfer.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request taken while one is in work");

  // Error results carry seat zero.
  a_err_seat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != STATUS_OK) |-> (m_axis_tdata[10:0] == '0))
    else $error("error result with a seat");

  // Successful results name a real seat.
  a_ok_seat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == STATUS_OK) |-> (m_axis_tdata[10:0] != '0))
    else $error("good result with seat zero");

  // Status is one of the defined codes.
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == STATUS_OK) || (m_axis_tuser == STATUS_FULL) ||
                      (m_axis_tuser == STATUS_NOT_SEATED))
    else $error("undefined status code");

endmodule

bind largest_gap_midpoint_seat_allocator lgms_checker u_lgms_checker (.*);

### bench/seat_allocation_checker.sv
`timescale 1ns / 100ps
// Result checker for the largest-gap midpoint seat allocator. It watches both
// streams and the register port, keeps its own seat map and compares each result.
// Depends on lgms_pkg.
module seat_allocation_checker
  import lgms_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,   // [9:0] student, [15:10] zero
  input  logic [0:0]             s_axis_tuser,   // [0] mode
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_DATA_W-1:0]  m_axis_tdata,   // [10:0] seat, [21:11] min_distance,
                                                 // [22] distance_ok, [23] zero
  input  logic [STATUS_W-1:0]    m_axis_tuser,   // [1:0] status
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata,
  output int                     failures,
  output int                     outstanding
);

  localparam int ROW_MAX = DEF_MAX_SEATS;

  typedef struct packed {
    logic [SEAT_W-1:0]     seat;
    logic [MIN_DIST_W-1:0] min_dist;
    logic                  dist_ok;
    logic [STATUS_W-1:0]   status;
  } seat_result_t;

  // Model of the row: occupancy including both walls, owner table and limits.
  bit                occupied [0:ROW_MAX+1];
  logic [SEAT_W-1:0] seat_of  [0:STUDENT_IDS-1];
  int                seats;
  int                min_spacing;
  int                spacing_goal;
  seat_result_t      seat_results_due [$];

  function automatic int clamp_seats(input int v);
    if (v < 1) return 1;
    if (v > ROW_MAX) return ROW_MAX;
    return v;
  endfunction

  // Empties the row and the owner table; only the two walls stay set.
  function automatic void clear_row();
    for (int p = 0; p <= ROW_MAX + 1; p++) occupied[p] = 1'b0;
    for (int i = 0; i < STUDENT_IDS; i++) seat_of[i] = '0;
    occupied[0] = 1'b1;
    occupied[seats + 1] = 1'b1;
    min_spacing = seats + 1;
  endfunction

  // Serves one request against the model and returns the result it must give.
  function automatic seat_result_t serve_request(input logic mode,
                                                 input logic [STUDENT_W-1:0] id);
    seat_result_t res;
    int prev, best_half, best_l, best_r, half, mid;
    bit found;
    res = '0;
    res.status = STATUS_OK;
    if (mode == MODE_ENTER) begin
      prev = 0;
      best_half = 0;
      best_l = 0;
      best_r = 0;
      found = 1'b0;
      // Widest half-gap wins; a later gap must be strictly wider to take over.
      for (int p = 1; p <= seats + 1; p++) begin
        if (occupied[p]) begin
          half = (p - prev) / 2;
          if (!found || half > best_half) begin
            best_half = half;
            best_l = prev;
            best_r = p;
            found = 1'b1;
          end
          prev = p;
        end
      end
      if (best_half == 0) begin
        res.status = STATUS_FULL;
      end else begin
        mid = (best_l + best_r) / 2;
        // Distances to the walls do not count towards the running minimum.
        if (best_l != 0 && mid - best_l < min_spacing) min_spacing = mid - best_l;
        if (best_r != seats + 1 && best_r - mid < min_spacing) min_spacing = best_r - mid;
        occupied[mid] = 1'b1;
        seat_of[id] = SEAT_W'(mid);
        res.seat = SEAT_W'(mid);
      end
    end else begin
      if (seat_of[id] == 0 || seat_of[id] > seats) begin
        res.status = STATUS_NOT_SEATED;
      end else begin
        res.seat = seat_of[id];
        occupied[seat_of[id]] = 1'b0;
        seat_of[id] = '0;
      end
    end
    res.min_dist = MIN_DIST_W'(min_spacing);
    res.dist_ok = (min_spacing >= spacing_goal);
    return res;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      failures++;
    end
  endfunction

  // Register writes, accepted requests and accepted results, sampled at the edge.
  always @(posedge clk) begin
    seat_result_t got, want;
    if (rst) begin
      seats = clamp_seats(SEAT_COUNT_RESET);
      spacing_goal = REQ_DIST_RESET;
      clear_row();
      seat_results_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_SEAT_COUNT) begin
          seats = clamp_seats(int'(cfg_wdata));
          clear_row();
        end else if (cfg_index == CFG_REQ_DIST) begin
          spacing_goal = int'(cfg_wdata);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        seat_results_due.push_back(serve_request(s_axis_tuser[0],
                                                 s_axis_tdata[STUDENT_W-1:0]));
      if (m_axis_tvalid && m_axis_tready) begin
        got.seat     = m_axis_tdata[SEAT_W-1:0];
        got.min_dist = m_axis_tdata[SEAT_W +: MIN_DIST_W];
        got.dist_ok  = m_axis_tdata[SEAT_W + MIN_DIST_W];
        got.status   = m_axis_tuser;
        if (seat_results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual seat %0d status %0d",
                   $time, got.seat, got.status);
          failures++;
        end else begin
          want = seat_results_due.pop_front();
          check_field("seat", want.seat, got.seat);
          check_field("min_distance", want.min_dist, got.min_dist);
          check_field("distance_ok", want.dist_ok, got.dist_ok);
          check_field("status", want.status, got.status);
        end
      end
    end
    outstanding = seat_results_due.size();
  end

endmodule

### bench/largest_gap_midpoint_seat_allocator_tb.sv
`timescale 1ns / 100ps
// Top of the seat allocator testbench: clock, reset, request and register
// stimulus, result back-pressure, watchdog and verdict.
// Depends on lgms_pkg, the allocator RTL and seat_allocation_checker.
module largest_gap_midpoint_seat_allocator_tb;
  import lgms_pkg::*;

  // The watchdog limit lies well above the quiet stretch of a full scan plus a
  // clearing pass, the long hold-off and the worst gaps.
  localparam int IDLE_LIMIT   = 20000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 1100;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata;   // [9:0] student, [15:10] zero
  logic [0:0]             s_axis_tuser;   // [0] mode
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;   // [10:0] seat, [21:11] min_distance,
                                          // [22] distance_ok, [23] zero
  logic [STATUS_W-1:0]    m_axis_tuser;   // [1:0] status
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_W-1:0]       cfg_wdata;

  int failures;
  int outstanding;
  int idle_cycles = 0;
  bit tx_gaps = 1'b1;
  bit rx_stalls = 1'b1;
  bit hold_request = 1'b0;
  int seated_ids [$];

  always #5 clk = ~clk;

  largest_gap_midpoint_seat_allocator u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  seat_allocation_checker u_seat_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .failures      (failures),
    .outstanding   (outstanding)
  );

  // Result receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int stall_left;
    m_axis_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (rx_stalls && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 12);
      end
    end
  end

  // Watchdog on cycles without any transfer or register write.
  always @(posedge clk) begin
    if (rst || cfg_we || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("largest_gap_midpoint_seat_allocator regression: fail");
      $finish;
    end
  end

  // Offers one request and returns at the edge of its transfer.
  task automatic offer(input logic mode, input int id);
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'(id);
    s_axis_tuser  <= mode;
    @(negedge clk);
    while (!s_axis_tready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every result is in and the block takes requests again.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding != 0 || !s_axis_tready);
    @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic start_phase(input int seat_value, input int goal);
    settle();
    write_register(CFG_REQ_DIST, goal);
    write_register(CFG_SEAT_COUNT, seat_value);
    seated_ids.delete();
  endtask

  // Mostly enters and leaves of seated students, with some stray leaves and
  // repeated enters mixed in.
  task automatic random_request();
    int r, k, id;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      offer(MODE_LEAVE, $urandom_range(0, STUDENT_IDS - 1));
    end else if (r < 14 && seated_ids.size() != 0) begin
      offer(MODE_ENTER, seated_ids[$urandom_range(0, seated_ids.size() - 1)]);
    end else if (r < 60 || seated_ids.size() == 0) begin
      id = $urandom_range(0, STUDENT_IDS - 1);
      seated_ids.push_back(id);
      offer(MODE_ENTER, id);
    end else begin
      k = $urandom_range(0, seated_ids.size() - 1);
      id = seated_ids[k];
      seated_ids.delete(k);
      offer(MODE_LEAVE, id);
    end
  endtask

  // Main sequence.
  initial begin
    int seat_value, goal, n_items;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Four seats: stray leave, fill to full, re-enter, double leave.
    start_phase(4, 0);
    offer(MODE_LEAVE, 0);
    offer(MODE_ENTER, 0);
    offer(MODE_ENTER, 1023);
    offer(MODE_ENTER, 5);
    offer(MODE_ENTER, 5);
    offer(MODE_ENTER, 7);
    offer(MODE_LEAVE, 5);
    offer(MODE_LEAVE, 5);
    offer(MODE_LEAVE, 1023);
    offer(MODE_ENTER, 512);
    offer(MODE_LEAVE, 0);
    offer(MODE_ENTER, 7);

    // A seat count of zero is taken as a single seat.
    start_phase(0, 2047);
    offer(MODE_ENTER, 1);
    offer(MODE_ENTER, 2);
    offer(MODE_LEAVE, 1);
    offer(MODE_LEAVE, 2);
    offer(MODE_ENTER, 682);

    // The widest field value is held to the largest row.
    start_phase(2047, 1025);
    offer(MODE_ENTER, 341);
    offer(MODE_ENTER, 0);
    offer(MODE_ENTER, 1023);
    offer(MODE_LEAVE, 341);
    offer(MODE_ENTER, 7);

    // Random phases, mostly on short rows; the last two run without idling.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin seat_value = $urandom_range(2, 8);       n_items = 80; end
        1: begin seat_value = $urandom_range(9, 40);      n_items = 80; end
        2: begin seat_value = 3;                          n_items = 60; end
        3: begin seat_value = $urandom_range(1025, 2047); n_items = 12; end
        4: begin seat_value = $urandom_range(41, 200);    n_items = 70; end
        5: begin seat_value = $urandom_range(0, 6);       n_items = 80; end
        6: begin seat_value = $urandom_range(2, 30);      n_items = 90; end
        default: begin seat_value = $urandom_range(2, 16); n_items = 90; end
      endcase
      goal = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 5);
      start_phase(seat_value, goal);
      tx_gaps = (p < 6) && (p != 4);
      rx_stalls = (p < 6) && (p != 1);
      for (int i = 0; i < n_items; i++) begin
        if (p == 2 && i == 10) hold_request = 1'b1;
        random_request();
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && outstanding == 0)
      $display("largest_gap_midpoint_seat_allocator regression: pass");
    else
      $display("largest_gap_midpoint_seat_allocator regression: fail");
    $finish;
  end

endmodule

### largest_gap_midpoint_seat_allocator.f
sv/lgms_pkg.sv
sv/lgms_ram.sv
sv/lgms_gap_unit.sv
sv/largest_gap_midpoint_seat_allocator.sv
sv/lgms_checker.sv
bench/seat_allocation_checker.sv
bench/largest_gap_midpoint_seat_allocator_tb.sv
